// ===== hdl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the byte-wise UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned FifoDepth = 4;
   localparam int unsigned PtrWidth  = $clog2(FifoDepth);
   localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

   localparam logic [CpWidth-1:0] MinLen1 = 21'h000080;
   localparam logic [CpWidth-1:0] MaxLen1 = 21'h0007FF;
   localparam logic [CpWidth-1:0] MinLen2 = 21'h000800;
   localparam logic [CpWidth-1:0] MaxLen2 = 21'h00FFFF;
   localparam logic [CpWidth-1:0] MinLen3 = 21'h010000;
   localparam logic [CpWidth-1:0] MaxLen3 = 21'h10FFFF;

   localparam logic [1:0] SeqLen1 = 2'd1;
   localparam logic [1:0] SeqLen2 = 2'd2;
   localparam logic [1:0] SeqLen3 = 2'd3;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               bad_sequence;
      logic               last_of_run;
   } result_type;

endpackage

// ===== hdl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Flow: a byte is registered, decoded while the output queue has room and its
// results are written to the output queue, from which they are read in order.
// Throughput: one input byte per cycle; a byte that yields two results sends
// them one at a time on the single result port, and input stalls while more than
// two results wait in the 4-entry output queue.
// Reset (synchronous): closes any open sequence and empties the output queue.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic               rsp_bad_sequence,
   output logic               rsp_last_of_run
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic [1:0]         pending_ff, pending_in;
   logic [1:0]         len_ff, len_in;
   logic [CpWidth-1:0] partial_ff, partial_in;

   result_type         fifo_ff [FifoDepth];
   logic [PtrWidth-1:0] wr_ff, rd_ff;
   logic [CntWidth-1:0] count_ff, count_in;

   logic               advance, pop;
   logic [1:0]         n_res;
   result_type         res0, res1;

   // fresh-byte decode
   logic               f_emit, f_bad, f_open;
   logic [1:0]         f_len;
   logic [CpWidth-1:0] f_cp, f_part;

   logic [7:0]         b;
   logic [1:0]         dec_pend;
   logic [CpWidth-1:0] asm_val;
   logic [CpWidth-1:0] lo, hi;

   assign b         = in_byte_ff;
   assign advance   = in_valid_ff && (count_ff <= CntWidth'(FifoDepth - 2));
   assign req_ready = !in_valid_ff || advance;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      f_emit = 1'b0;
      f_bad  = 1'b0;
      f_open = 1'b0;
      f_len  = 2'd0;
      f_cp   = '0;
      f_part = '0;
      if (b[7] == 1'b0) begin
         f_emit = 1'b1;
         f_cp   = CpWidth'(b);
      end else if (b[7:5] == 3'b110) begin
         f_open = 1'b1;
         f_len  = SeqLen1;
         f_part = CpWidth'({b[4:0], 6'd0});
      end else if (b[7:4] == 4'b1110) begin
         f_open = 1'b1;
         f_len  = SeqLen2;
         f_part = CpWidth'({b[3:0], 12'd0});
      end else if (b[7:3] == 5'b11110) begin
         f_open = 1'b1;
         f_len  = SeqLen3;
         f_part = {b[2:0], 18'd0};
      end else begin
         f_emit = 1'b1;
         f_bad  = 1'b1;
      end
   end

   always_comb begin
      dec_pend = pending_ff - 2'd1;
      unique case (dec_pend)
         2'd0:    asm_val = partial_ff | CpWidth'(b[5:0]);
         2'd1:    asm_val = partial_ff | CpWidth'({b[5:0], 6'd0});
         default: asm_val = partial_ff | CpWidth'({b[5:0], 12'd0});
      endcase
      unique case (len_ff)
         SeqLen1: begin
            lo = MinLen1;
            hi = MaxLen1;
         end
         SeqLen2: begin
            lo = MinLen2;
            hi = MaxLen2;
         end
         default: begin
            lo = MinLen3;
            hi = MaxLen3;
         end
      endcase
   end

   always_comb begin
      pending_in = pending_ff;
      len_in     = len_ff;
      partial_in = partial_ff;
      n_res      = 2'd0;
      res0       = '0;
      res1       = '0;
      if (advance) begin
         if (pending_ff == 2'd0) begin
            if (f_emit) begin
               n_res = 2'd1;
               res0  = '{code_point: f_cp, bad_sequence: f_bad, last_of_run: 1'b1};
            end
            if (f_open) begin
               pending_in = f_len;
               len_in     = f_len;
               partial_in = f_part;
            end
         end else if (b[7:6] == 2'b10) begin
            pending_in = dec_pend;
            partial_in = asm_val;
            if (dec_pend == 2'd0) begin
               n_res      = 2'd1;
               len_in     = 2'd0;
               partial_in = '0;
               if (asm_val < lo || asm_val > hi) begin
                  res0 = '{code_point: '0, bad_sequence: 1'b1, last_of_run: 1'b1};
               end else begin
                  res0 = '{code_point: asm_val, bad_sequence: 1'b0, last_of_run: 1'b1};
               end
            end
         end else begin
            res0       = '{code_point: '0, bad_sequence: 1'b1, last_of_run: !f_emit};
            pending_in = 2'd0;
            len_in     = 2'd0;
            partial_in = '0;
            if (f_emit) begin
               n_res = 2'd2;
               res1  = '{code_point: f_cp, bad_sequence: f_bad, last_of_run: 1'b1};
            end else begin
               n_res = 2'd1;
            end
            if (f_open) begin
               pending_in = f_len;
               len_in     = f_len;
               partial_in = f_part;
            end
         end
      end
      count_in = count_ff + CntWidth'(n_res) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= 2'd0;
         len_ff      <= 2'd0;
         partial_ff  <= '0;
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         pending_ff <= pending_in;
         len_ff     <= len_in;
         partial_ff <= partial_in;
         wr_ff      <= wr_ff + PtrWidth'(n_res);
         rd_ff      <= rd_ff + PtrWidth'(pop);
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (n_res != 2'd0) begin
         fifo_ff[wr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ff + PtrWidth'(1)] <= res1;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_code_point   = fifo_ff[rd_ff].code_point;
   assign rsp_bad_sequence = fifo_ff[rd_ff].bad_sequence;
   assign rsp_last_of_run  = fifo_ff[rd_ff].last_of_run;

endmodule
